// File: src/qkd_pkg.sv
`default_nettype none

package qkd_pkg;

  // Widths of the counter and of the configuration address.
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned IDX_W  = 3;

  // Register indexes on the configuration port.
  localparam logic [IDX_W-1:0] REG_SWITCH_MODE  = 3'd0;
  localparam logic [IDX_W-1:0] REG_LIMIT_ENABLE = 3'd1;
  localparam logic [IDX_W-1:0] REG_MIN_VALUE    = 3'd2;
  localparam logic [IDX_W-1:0] REG_MAX_VALUE    = 3'd3;
  localparam logic [IDX_W-1:0] REG_START_VALUE  = 3'd4;

  // Reset values of the registers and of the decoder state.
  localparam logic [VAL_W-1:0] MIN_RESET       = '1;
  localparam logic [VAL_W-1:0] MAX_RESET       = '1;
  localparam logic [VAL_W-1:0] START_RESET     = '0;
  localparam logic [VAL_W-1:0] LAST_READ_RESET = '1;

  // Pin codes of the two-pin Gray sequence.
  localparam logic [1:0] CODE_00 = 2'd0;
  localparam logic [1:0] CODE_A  = 2'd1;
  localparam logic [1:0] CODE_B  = 2'd2;
  localparam logic [1:0] CODE_AB = 2'd3;

  // Settings that the decoder core reads.
  typedef struct packed {
    logic             switch_mode;
    logic             limit_enable;
    logic [VAL_W-1:0] min_value;
    logic [VAL_W-1:0] max_value;
  } cfg_t;

  // Load of the counter on a write of the start value.
  typedef struct packed {
    logic             load;
    logic [VAL_W-1:0] value;
  } load_t;

  // Clockwise transition: 0 -> 2 -> 3 -> 1 -> 0.
  function automatic logic is_cw(input logic [1:0] from, input logic [1:0] to);
    return (from == CODE_00 && to == CODE_B)  || (from == CODE_B && to == CODE_AB) ||
           (from == CODE_AB && to == CODE_A)  || (from == CODE_A && to == CODE_00);
  endfunction

  // Counterclockwise transition: 0 -> 1 -> 3 -> 2 -> 0.
  function automatic logic is_ccw(input logic [1:0] from, input logic [1:0] to);
    return (from == CODE_00 && to == CODE_A)  || (from == CODE_A && to == CODE_AB) ||
           (from == CODE_AB && to == CODE_B)  || (from == CODE_B && to == CODE_00);
  endfunction

endpackage

`default_nettype wire

// File: src/qkd_if.sv
`default_nettype none

// Channel that carries one pin sample item.
interface qkd_in_if;
  logic valid;
  logic ready;
  logic pin_a;
  logic pin_b;
  logic read_request;

  modport source (output valid, pin_a, pin_b, read_request, input ready);
  modport sink   (input valid, pin_a, pin_b, read_request, output ready);
endinterface

// Channel that carries one result item.
interface qkd_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] knob_value;
  logic        changed;

  modport source (output valid, knob_value, changed, input ready);
  modport sink   (input valid, knob_value, changed, output ready);
endinterface

`default_nettype wire

// File: src/qkd_regs.sv
`default_nettype none

module qkd_regs
  import qkd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  output cfg_t                   cfg,
  output load_t                  start_load
);

  logic             switch_mode_r;
  logic             limit_enable_r;
  logic [VAL_W-1:0] min_value_r;
  logic [VAL_W-1:0] max_value_r;
  logic [VAL_W-1:0] start_value_r;
  logic [IDX_W-1:0] idx;
  logic             wr_en;

  assign idx    = paddr[ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  // Register writes in the access cycle; unused indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      switch_mode_r  <= 1'b0;
      limit_enable_r <= 1'b0;
      min_value_r    <= MIN_RESET;
      max_value_r    <= MAX_RESET;
      start_value_r  <= START_RESET;
    end else if (wr_en) begin
      case (idx)
        REG_SWITCH_MODE:  switch_mode_r  <= pwdata[0];
        REG_LIMIT_ENABLE: limit_enable_r <= pwdata[0];
        REG_MIN_VALUE:    min_value_r    <= pwdata;
        REG_MAX_VALUE:    max_value_r    <= pwdata;
        REG_START_VALUE:  start_value_r  <= pwdata;
        default: ;
      endcase
    end
  end

  // Read back.
  always_comb begin
    case (idx)
      REG_SWITCH_MODE:  prdata = {31'd0, switch_mode_r};
      REG_LIMIT_ENABLE: prdata = {31'd0, limit_enable_r};
      REG_MIN_VALUE:    prdata = min_value_r;
      REG_MAX_VALUE:    prdata = max_value_r;
      REG_START_VALUE:  prdata = start_value_r;
      default:          prdata = '0;
    endcase
  end

  assign cfg.switch_mode  = switch_mode_r;
  assign cfg.limit_enable = limit_enable_r;
  assign cfg.min_value    = min_value_r;
  assign cfg.max_value    = max_value_r;

  // A write of the start value also loads the counter.
  assign start_load.load  = wr_en && (idx == REG_START_VALUE);
  assign start_load.value = pwdata;

endmodule

`default_nettype wire

// File: src/qkd_step.sv
`default_nettype none

module qkd_step
  import qkd_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             step_en,
  input  wire logic             pin_a,
  input  wire logic             pin_b,
  input  wire logic             read_request,
  input  wire cfg_t             cfg,
  input  wire load_t            start_load,
  output logic      [VAL_W-1:0] knob_value,
  output logic                  changed
);

  logic [VAL_W-1:0] count_r, count_nxt;
  logic [1:0]       prev_pins_r;
  logic             prev_known_r;
  logic             dir_up_r, dir_up_nxt;
  logic [VAL_W-1:0] last_read_r;

  logic [1:0]       code;
  logic             moved;
  logic             cw;
  logic             ccw;
  logic             go_up;
  logic             up_ok;
  logic             down_ok;
  logic             odd_step;

  assign code  = cfg.switch_mode ? {1'b0, pin_a} : {pin_b, pin_a};
  assign moved = !prev_known_r || (code != prev_pins_r);
  assign cw    = is_cw(prev_pins_r, code);
  assign ccw   = is_ccw(prev_pins_r, code);
  // An illegal double jump repeats the last direction.
  assign go_up = cw || (!ccw && dir_up_r);

  assign up_ok   = !cfg.limit_enable || ($signed(count_r) < $signed(cfg.max_value));
  assign down_ok = !cfg.limit_enable || ($signed(count_r) > $signed(cfg.min_value));

  // In switch mode a step of one lands on the wanted parity, else two.
  assign odd_step = pin_a ^ count_r[0];

  // Next counter value and direction for this sample.
  always_comb begin
    count_nxt  = count_r;
    dir_up_nxt = dir_up_r;
    if (moved) begin
      if (cfg.switch_mode) begin
        count_nxt = count_r + (odd_step ? VAL_W'(1) : VAL_W'(2));
      end else if (prev_known_r) begin
        if (cw) begin
          dir_up_nxt = 1'b1;
        end else if (ccw) begin
          dir_up_nxt = 1'b0;
        end
        if (go_up) begin
          if (up_ok) begin
            count_nxt = count_r + VAL_W'(1);
          end
        end else if (down_ok) begin
          count_nxt = count_r - VAL_W'(1);
        end
      end
    end
  end

  // The read is answered after the sample is applied.
  assign knob_value = count_nxt;
  assign changed    = read_request && (count_nxt != last_read_r);

  // Decoder state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= START_RESET;
      prev_pins_r  <= CODE_00;
      prev_known_r <= 1'b0;
      dir_up_r     <= 1'b1;
      last_read_r  <= LAST_READ_RESET;
    end else if (start_load.load) begin
      count_r <= start_load.value;
    end else if (step_en) begin
      count_r  <= count_nxt;
      dir_up_r <= dir_up_nxt;
      if (moved) begin
        prev_pins_r  <= code;
        prev_known_r <= 1'b1;
      end
      if (changed) begin
        last_read_r <= count_nxt;
      end
    end
  end

endmodule

`default_nettype wire

// File: src/quadrature_knob_decoder.sv
`default_nettype none

// Items pass the input and result registers in turn; out_ch can hold them.
// Throughput: one item per cycle; the counter update is a single compare and add.
// Input register and result register both advance when the result is taken or empty.
// Reset is synchronous, active low: valid flags, config, decoder state to defaults.
module quadrature_knob_decoder
  import qkd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  qkd_in_if.sink                 in_ch,
  qkd_out_if.source              out_ch,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready
);

  cfg_t             cfg;
  load_t            start_load;

  logic             in_vld_r;
  logic             pin_a_r;
  logic             pin_b_r;
  logic             read_req_r;
  logic             out_vld_r;
  logic [VAL_W-1:0] knob_value_r;
  logic             changed_r;

  logic             advance;
  logic [VAL_W-1:0] knob_value;
  logic             changed;

  qkd_regs u_regs (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .cfg        (cfg),
    .start_load (start_load)
  );

  // The held item moves into the result register when that register is free.
  assign advance     = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !in_vld_r || advance;

  qkd_step u_step (
    .clk          (clk),
    .rst_n        (rst_n),
    .step_en      (advance),
    .pin_a        (pin_a_r),
    .pin_b        (pin_b_r),
    .read_request (read_req_r),
    .cfg          (cfg),
    .start_load   (start_load),
    .knob_value   (knob_value),
    .changed      (changed)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      pin_a_r    <= in_ch.pin_a;
      pin_b_r    <= in_ch.pin_b;
      read_req_r <= in_ch.read_request;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      knob_value_r <= knob_value;
      changed_r    <= changed;
    end
  end

  assign out_ch.valid      = out_vld_r;
  assign out_ch.knob_value = knob_value_r;
  assign out_ch.changed    = changed_r;

endmodule

`default_nettype wire

// File: tb/quadrature_knob_decoder_tb.sv
`default_nettype none

module quadrature_knob_decoder_tb
  import qkd_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 6;

  localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;

  localparam logic [VAL_W-1:0] INT_MAX_32 = 32'h7FFF_FFFF;
  localparam logic [VAL_W-1:0] INT_MIN_32 = 32'h8000_0000;

  // One result item: counter value and change flag.
  typedef struct packed {
    logic [VAL_W-1:0] knob_value;
    logic             changed;
  } knob_result_t;

  logic clk = 1'b0;
  logic rst_n;

  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  qkd_in_if  in_if ();
  qkd_out_if out_if ();

  quadrature_knob_decoder u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always #5 clk = ~clk;

  // Knob state as the decoder should hold it.
  logic             mode_switch;
  logic             clamp_on;
  logic [VAL_W-1:0] floor_value;
  logic [VAL_W-1:0] ceil_value;
  logic [VAL_W-1:0] counter;
  logic [1:0]       held_code;
  logic             held_valid;
  logic             spin_up;
  logic [VAL_W-1:0] read_mark;

  knob_result_t predicted_knob[$];
  int           error_count  = 0;
  int           quiet_cycles = 0;
  int           max_gap      = 5;
  int           max_stall    = 5;

  // Random walk over the pin codes.
  logic [1:0] walk_code;
  logic       walk_cw;

  function automatic logic [1:0] cw_next(input logic [1:0] code);
    case (code)
      CODE_00: return CODE_B;
      CODE_B:  return CODE_AB;
      CODE_AB: return CODE_A;
      default: return CODE_00;
    endcase
  endfunction

  function automatic logic [1:0] ccw_next(input logic [1:0] code);
    case (code)
      CODE_00: return CODE_A;
      CODE_A:  return CODE_AB;
      CODE_AB: return CODE_B;
      default: return CODE_00;
    endcase
  endfunction

  function automatic void count_up();
    if (!clamp_on || $signed(counter) < $signed(ceil_value)) counter = counter + 1'b1;
  endfunction

  function automatic void count_down();
    if (!clamp_on || $signed(counter) > $signed(floor_value)) counter = counter - 1'b1;
  endfunction

  // Apply one pin sample to the knob state and answer the read.
  function automatic knob_result_t decode_sample(input logic a, input logic b, input logic rd);
    logic [1:0]   code;
    knob_result_t res;
    code = mode_switch ? {1'b0, a} : {b, a};
    if (!held_valid || code != held_code) begin
      if (mode_switch) begin
        // Pressed moves to the next even value, released to the next odd one.
        if (code == CODE_00) counter = counter + (counter[0] ? 32'd1 : 32'd2);
        else counter = counter + (counter[0] ? 32'd2 : 32'd1);
      end else if (held_valid) begin
        if (code == cw_next(held_code)) begin
          spin_up = 1'b1;
          count_up();
        end else if (code == ccw_next(held_code)) begin
          spin_up = 1'b0;
          count_down();
        end else if (spin_up) begin
          // A jump of two steps keeps the last direction.
          count_up();
        end else begin
          count_down();
        end
      end
      held_code  = code;
      held_valid = 1'b1;
    end
    res.changed = 1'b0;
    if (rd && counter != read_mark) begin
      res.changed = 1'b1;
      read_mark   = counter;
    end
    res.knob_value = counter;
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Send one sample item and record its predicted result once accepted.
  task automatic send_sample(input logic a, input logic b, input logic rd);
    int gap;
    gap = $urandom_range(0, max_gap);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid        <= 1'b1;
    in_if.pin_a        <= a;
    in_if.pin_b        <= b;
    in_if.read_request <= rd;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    predicted_knob.push_back(decode_sample(a, b, rd));
  endtask

  task automatic send_code(input logic [1:0] code, input logic rd);
    send_sample(code[0], code[1], rd);
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (predicted_knob.size() != 0) @(posedge clk);
  endtask

  task automatic wait_idle();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write: setup cycle, access cycle, then back to idle.
  task automatic write_register(input logic [IDX_W-1:0] idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(idx) << 2;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_SWITCH_MODE:  mode_switch = data[0];
      REG_LIMIT_ENABLE: clamp_on    = data[0];
      REG_MIN_VALUE:    floor_value = data;
      REG_MAX_VALUE:    ceil_value  = data;
      REG_START_VALUE:  counter     = data;
      default: ;
    endcase
  endtask

  task automatic configure(input logic sw, input logic lim, input logic [31:0] lo,
                           input logic [31:0] hi, input logic [31:0] start);
    wait_idle();
    write_register(REG_SWITCH_MODE, {31'd0, sw});
    write_register(REG_LIMIT_ENABLE, {31'd0, lim});
    write_register(REG_MIN_VALUE, lo);
    write_register(REG_MAX_VALUE, hi);
    write_register(REG_START_VALUE, start);
  endtask

  // First sample, reads, both turning directions and jumps of two.
  task automatic test_encoder_directed();
    send_code(CODE_00, 1'b1);
    send_code(CODE_00, 1'b1);
    send_code(CODE_B, 1'b0);
    send_code(CODE_AB, 1'b0);
    send_code(CODE_A, 1'b1);
    send_code(CODE_AB, 1'b0);
    send_code(CODE_00, 1'b0);
    send_code(CODE_AB, 1'b0);
    send_code(CODE_B, 1'b1);
  endtask

  // Unlimited steps wrap across the signed extremes.
  task automatic test_wrap();
    wait_idle();
    write_register(REG_START_VALUE, INT_MAX_32);
    send_code(CODE_AB, 1'b1);
    wait_idle();
    write_register(REG_START_VALUE, INT_MIN_32);
    send_code(CODE_B, 1'b1);
  endtask

  // Clamping at min and max, min above max, and the widest window.
  task automatic test_limits();
    configure(1'b0, 1'b1, 32'hFFFF_FFFF, 32'd1, 32'd0);
    send_code(CODE_AB, 1'b0);
    send_code(CODE_A, 1'b1);
    send_code(CODE_AB, 1'b0);
    send_code(CODE_B, 1'b0);
    send_code(CODE_00, 1'b1);
    configure(1'b0, 1'b1, 32'd5, -32'sd5, 32'd0);
    send_code(CODE_AB, 1'b1);
    configure(1'b0, 1'b1, INT_MIN_32, INT_MAX_32, INT_MAX_32);
    send_code(CODE_A, 1'b1);
    wait_idle();
    write_register(REG_START_VALUE, INT_MIN_32);
    send_code(CODE_AB, 1'b1);
  endtask

  // Switch mode entered with a stored code of three, negative parity, wrap.
  task automatic test_switch_mode();
    configure(1'b1, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, -32'sd3);
    send_sample(1'b1, 1'b1, 1'b0);
    send_sample(1'b1, 1'b0, 1'b0);
    send_sample(1'b0, 1'b1, 1'b1);
    send_sample(1'b1, 1'b0, 1'b0);
    wait_idle();
    write_register(REG_START_VALUE, INT_MAX_32);
    send_sample(1'b0, 1'b0, 1'b1);
    wait_idle();
    write_register(REG_UNUSED, 32'hFFFF_FFFF);
    write_register(REG_START_VALUE, -32'sd2);
    send_sample(1'b1, 1'b1, 1'b1);
  endtask

  // Mostly Gray-code walks, with holds, jumps and random codes mixed in.
  task automatic run_random_phase(input int n_items, input int gap_max, input bit drain_midway);
    int   roll;
    logic a;
    logic b;
    max_gap   = gap_max;
    max_stall = gap_max;
    walk_code = held_code;
    walk_cw   = $urandom_range(0, 1);
    for (int i = 0; i < n_items; i++) begin
      if (drain_midway && i == n_items / 2) wait_drained();
      if (mode_switch) begin
        a = $urandom_range(0, 1);
        b = $urandom_range(0, 1);
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 8) walk_cw = ~walk_cw;
        if (roll < 75) walk_code = walk_cw ? cw_next(walk_code) : ccw_next(walk_code);
        else if (roll >= 85 && roll < 93) walk_code = walk_code ^ 2'b11;
        else if (roll >= 93) walk_code = 2'($urandom_range(0, 3));
        a = walk_code[0];
        b = walk_code[1];
      end
      send_sample(a, b, $urandom_range(0, 3) == 0);
    end
  endtask

  task automatic test_random();
    logic [31:0] s;
    logic [31:0] t;
    for (int phase = 0; phase < 8; phase++) begin
      s = $urandom;
      t = $urandom;
      case (phase)
        0: configure(1'b0, 1'b0, t, ~t, s);
        1: configure(1'b0, 1'b1, s - 32'd3, s + 32'd3, s);
        2: configure(1'b0, 1'b1, INT_MAX_32, INT_MIN_32, s);
        3: configure(1'b0, 1'b1, INT_MIN_32, INT_MAX_32, INT_MAX_32 - 32'd2);
        4: configure(1'b0, 1'b0, s, t, INT_MIN_32 + 32'd1);
        5: configure(1'b1, 1'b0, s, t, s);
        6: configure(1'b1, 1'b1, t, s, INT_MAX_32 - 32'd2);
        default: configure(1'b0, 1'b1, s, s, s);
      endcase
      run_random_phase(50, (phase == 0) ? 0 : 5, phase == 3);
    end
    max_gap   = 5;
    max_stall = 5;
  endtask

  // Result side: random stalls, each result checked against the oldest prediction.
  initial begin
    knob_result_t want;
    int           stall;
    out_if.ready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      stall = $urandom_range(0, max_stall);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      @(posedge clk);
      while (!out_if.valid) @(posedge clk);
      if (predicted_knob.size() == 0) begin
        report_mismatch($sformatf("unexpected result item value %0d changed %0b",
                                  $signed(out_if.knob_value), out_if.changed));
      end else begin
        want = predicted_knob.pop_front();
        if (out_if.knob_value !== want.knob_value)
          report_mismatch($sformatf("knob_value got %0d expected %0d",
                                    $signed(out_if.knob_value), $signed(want.knob_value)));
        if (out_if.changed !== want.changed)
          report_mismatch($sformatf("changed got %0b expected %0b",
                                    out_if.changed, want.changed));
      end
    end
  end

  // Watchdog on cycles without any accepted item.
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    rst_n              <= 1'b0;
    in_if.valid        <= 1'b0;
    in_if.pin_a        <= 1'b0;
    in_if.pin_b        <= 1'b0;
    in_if.read_request <= 1'b0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;

    // State after reset.
    mode_switch = 1'b0;
    clamp_on    = 1'b0;
    floor_value = MIN_RESET;
    ceil_value  = MAX_RESET;
    counter     = START_RESET;
    held_code   = CODE_00;
    held_valid  = 1'b0;
    spin_up     = 1'b1;
    read_mark   = LAST_READ_RESET;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_encoder_directed();
    test_wrap();
    test_limits();
    test_switch_mode();
    test_random();

    wait_idle();
    if (predicted_knob.size() != 0)
      report_mismatch($sformatf("%0d result items never arrived", predicted_knob.size()));
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
